[rtl/brd_pkg.sv]
// Shared constants, codes, types and helpers for the balanced random draw block.
package brd_pkg;

  // Field and register widths
  localparam int BRD_MAX_RANGE = 64;
  localparam int RANGE_CFG_W   = 7;
  localparam int OFFSET_W      = 11;
  localparam int TOTAL_W       = 14;
  localparam int PICK_W        = 16;
  localparam int DRAWN_W       = 12;
  localparam int CNT_W         = 8;
  localparam int DRAW_CNT_W    = 14;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 14;

  localparam logic [CFG_IW-1:0] CFG_IDX_RANGE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IDX_OFFSET = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_IDX_TOTAL  = 2'd2;

  // Reset values of the settings
  localparam int RANGE_RESET = 12;
  localparam int TOTAL_RESET = 12;

  // Operation and direction codes
  localparam logic OP_DRAW  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic DIR_DOWN = 1'b1;

  // Jobs run on the shared divider
  typedef enum logic [1:0] {
    JOB_SNAP,
    JOB_CUR,
    JOB_PICK
  } div_job_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECALC,
    ST_DISPATCH,
    ST_PICK,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_UPDATE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_job_t div_job;
    logic     scan_init;
    logic     scan;
    logic     update;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cfg_write;
    logic apply_pend;
    logic cur_pend;
    logic op_draw;
    logic div_done;
    logic found;
    logic all_full;
    logic out_free;
  } dp_status_t;

  // Depth is never below one
  function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] q);
    return (q == '0) ? CNT_W'(1) : q;
  endfunction

endpackage

[rtl/brd_if.sv]
// Valid/ready channel interfaces for the draw requests and the drawn results.
interface brd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [brd_pkg::PICK_W-1:0]  random_pick;
  logic                        random_direction;

  modport source (output valid, output operation, output random_pick,
                  output random_direction, input ready);
  modport sink   (input valid, input operation, input random_pick,
                  input random_direction, output ready);
endinterface

interface brd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [brd_pkg::DRAWN_W-1:0] drawn_value;
  logic                               table_exhausted;

  modport source (output valid, output drawn_value, output table_exhausted,
                  input ready);
  modport sink   (input valid, input drawn_value, input table_exhausted,
                  output ready);
endinterface

[rtl/brd_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module brd_div #(
  parameter int VW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       abort,
  input  logic [brd_pkg::PICK_W-1:0] dividend,
  input  logic [VW-1:0]              divisor,
  output logic                       busy,
  output logic                       done,
  output logic [brd_pkg::PICK_W-1:0] quot,
  output logic [VW-1:0]              rem
);
  import brd_pkg::*;

  localparam int SW = $clog2(PICK_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [SW-1:0]     step_r;
  logic [PICK_W-1:0] quot_r;
  logic [VW-1:0]     rem_r;
  logic [VW-1:0]     dvs_r;
  logic [VW:0]       trial;
  logic [VW:0]       diff;
  logic              ge;

  // one trial subtraction per step
  always_comb begin
    trial = {rem_r, quot_r[PICK_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (abort) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + SW'(1);
      if (step_r == SW'(PICK_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[PICK_W-2:0], ge};
      rem_r  <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

[rtl/brd_dp.sv]
// Datapath: settings, use-count memory, scan pointer, divider and result register.
module brd_dp #(
  parameter int MAX_RANGE = brd_pkg::BRD_MAX_RANGE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [brd_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [brd_pkg::CFG_DW-1:0]         cfg_wdata,
  input  logic                               in_operation,
  input  logic [brd_pkg::PICK_W-1:0]         in_random_pick,
  input  logic                               in_random_direction,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [brd_pkg::DRAWN_W-1:0] out_drawn_value,
  output logic                               out_table_exhausted,
  input  brd_pkg::dp_cmd_t                   cmd,
  output brd_pkg::dp_status_t                status
);
  import brd_pkg::*;

  localparam int RW = $clog2(MAX_RANGE + 1);
  localparam int AW = $clog2(MAX_RANGE);
  localparam int RANGE_INIT = (RANGE_RESET > MAX_RANGE) ? MAX_RANGE : RANGE_RESET;

  // settings and derived values
  logic [RW-1:0]              range_r;
  logic signed [OFFSET_W-1:0] offset_r;
  logic [TOTAL_W-1:0]         total_r;
  logic [TOTAL_W-1:0]         snap_total_r;
  logic [RW-1:0]              snap_range_r;
  logic                       apply_pend_r;
  logic                       cur_pend_r;
  logic [CNT_W-1:0]           q_cur_r;
  logic                       rem_nz_r;
  logic [CNT_W-1:0]           allowed_r;
  logic                       last_round_r;
  logic [DRAW_CNT_W-1:0]      draw_cnt_r;

  // latched request
  logic              op_r;
  logic [PICK_W-1:0] pick_r;
  logic              dir_r;

  // divider
  div_job_t          div_job_r;
  logic [PICK_W-1:0] div_dvd;
  logic [RW-1:0]     div_dvs;
  logic              div_busy;
  logic              div_done;
  logic [PICK_W-1:0] div_quot;
  logic [RW-1:0]     div_rem;

  // use table
  logic [CNT_W-1:0]     cnt_mem [MAX_RANGE];
  logic [MAX_RANGE-1:0] valid_r;
  logic [CNT_W-1:0]     rdata_r;
  logic                 rvb_r;
  logic [AW-1:0]        raddr_q_r;
  logic                 table_clear;
  logic [CNT_W-1:0]     wr_cnt;

  // scan
  logic [AW-1:0]    cand_r;
  logic [AW-1:0]    pos_r;
  logic [AW-1:0]    pos_step;
  logic [RW-1:0]    chk_r;
  logic             live_r;
  logic [AW-1:0]    val_r;
  logic [CNT_W-1:0] found_cnt_r;
  logic             exh_r;
  logic [CNT_W-1:0] count_now;
  logic             free;

  // result register
  logic                      out_valid_r;
  logic signed [DRAWN_W-1:0] drawn_r;
  logic                      exh_out_r;

  // config decode and draw counter
  logic [RW-1:0]         range_clamp;
  logic                  range_accept;
  logic                  total_accept;
  logic                  q_ok;
  logic [DRAW_CNT_W-1:0] dc_inc;
  logic                  wrapped;
  logic                  wrap_apply;
  logic                  is_draw_in;

  // range clamp and the quotient-below-256 tests (q < 256 iff total < range*256)
  always_comb begin
    int r_i;
    r_i = int'(cfg_wdata[RANGE_CFG_W-1:0]);
    if (r_i < 1) begin
      r_i = 1;
    end
    if (r_i > MAX_RANGE) begin
      r_i = MAX_RANGE;
    end
    range_clamp  = RW'(r_i);
    range_accept = 32'(total_r) < (32'(range_clamp) << CNT_W);
    total_accept = 32'(cfg_wdata[TOTAL_W-1:0]) < (32'(range_r) << CNT_W);
    q_ok         = 32'(total_r) < (32'(range_r) << CNT_W);
  end

  // draw counter wrap
  always_comb begin
    is_draw_in = (in_operation == OP_DRAW);
    dc_inc     = draw_cnt_r + DRAW_CNT_W'(1);
    wrapped    = (total_r != '0) && (dc_inc >= total_r);
    wrap_apply = is_draw_in && wrapped && rem_nz_r;
  end

  // settings, depth and round state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r      <= RW'(RANGE_INIT);
      offset_r     <= '0;
      total_r      <= TOTAL_W'(TOTAL_RESET);
      snap_total_r <= TOTAL_W'(TOTAL_RESET);
      snap_range_r <= RW'(RANGE_INIT);
      apply_pend_r <= 1'b0;
      cur_pend_r   <= 1'b1;
      q_cur_r      <= CNT_W'(1);
      rem_nz_r     <= 1'b0;
      allowed_r    <= CNT_W'(1);
      last_round_r <= 1'b0;
      draw_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_RANGE: begin
            range_r      <= range_clamp;
            last_round_r <= 1'b0;
            cur_pend_r   <= 1'b1;
            if (range_accept) begin
              apply_pend_r <= 1'b1;
              snap_total_r <= total_r;
              snap_range_r <= range_clamp;
            end
          end
          CFG_IDX_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
          CFG_IDX_TOTAL: begin
            if (total_accept) begin
              total_r      <= cfg_wdata[TOTAL_W-1:0];
              apply_pend_r <= 1'b1;
              cur_pend_r   <= 1'b1;
              snap_total_r <= cfg_wdata[TOTAL_W-1:0];
              snap_range_r <= range_r;
            end
          end
          default: ;
        endcase
      end else if (div_done) begin
        case (div_job_r)
          JOB_SNAP: begin
            allowed_r    <= at_least_one(div_quot[CNT_W-1:0]);
            apply_pend_r <= 1'b0;
          end
          JOB_CUR: begin
            q_cur_r    <= div_quot[CNT_W-1:0];
            rem_nz_r   <= (div_rem != '0);
            cur_pend_r <= 1'b0;
          end
          default: ;
        endcase
      end
      // end of a full cycle of draws: restore the depth
      if (cmd.accept && is_draw_in) begin
        draw_cnt_r <= wrapped ? '0 : dc_inc;
        if (wrap_apply) begin
          last_round_r <= 1'b0;
          if (q_ok) begin
            allowed_r <= at_least_one(q_cur_r);
          end
        end
      end
      // table ran dry: one last round at depth one
      if (cmd.update && exh_r && rem_nz_r && !last_round_r) begin
        allowed_r    <= CNT_W'(1);
        last_round_r <= 1'b1;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      pick_r <= in_random_pick;
      dir_r  <= in_random_direction;
    end
  end

  // divider job select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_job_r <= JOB_PICK;
    end else if (cmd.div_start) begin
      div_job_r <= cmd.div_job;
    end
  end

  always_comb begin
    case (cmd.div_job)
      JOB_SNAP: begin
        div_dvd = PICK_W'(snap_total_r);
        div_dvs = snap_range_r;
      end
      JOB_CUR: begin
        div_dvd = PICK_W'(total_r);
        div_dvs = range_r;
      end
      default: begin
        div_dvd = pick_r;
        div_dvs = range_r;
      end
    endcase
  end

  brd_div #(
    .VW (RW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .abort    (cfg_we),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // table clear sources
  always_comb begin
    table_clear = (cfg_we && (cfg_index == CFG_IDX_RANGE)) ||
                  (cmd.accept && ((in_operation == OP_CLEAR) || wrap_apply)) ||
                  (cmd.update && exh_r);
    wr_cnt      = exh_r ? CNT_W'(1) : found_cnt_r + CNT_W'(1);
  end

  // per-entry valid flags: an entry not valid reads as zero uses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (table_clear) begin
      // a clear on update keeps only the entry just drawn
      valid_r <= cmd.update ? (MAX_RANGE'(1) << val_r) : '0;
    end else if (cmd.update) begin
      valid_r[val_r] <= 1'b1;
    end
  end

  // use-count memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cnt_mem[val_r] <= wr_cnt;
    end
    rdata_r   <= cnt_mem[pos_r];
    rvb_r     <= valid_r[pos_r];
    raddr_q_r <= pos_r;
  end

  // next scan position with wraparound
  always_comb begin
    if (dir_r == DIR_DOWN) begin
      pos_step = (pos_r == '0) ? AW'(range_r - RW'(1)) : pos_r - AW'(1);
    end else begin
      pos_step = ((RW'(pos_r) + RW'(1)) >= range_r) ? '0 : pos_r + AW'(1);
    end
    count_now = rvb_r ? rdata_r : '0;
    free      = (count_now < allowed_r);
  end

  // scan: one address issued and one entry checked per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else begin
      live_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done && (div_job_r == JOB_PICK)) begin
      cand_r <= div_rem[AW-1:0];
    end
    if (cmd.scan_init) begin
      pos_r <= cand_r;
      chk_r <= '0;
      exh_r <= 1'b0;
    end else if (cmd.scan) begin
      pos_r <= pos_step;
      if (live_r) begin
        chk_r <= chk_r + RW'(1);
        if (free) begin
          val_r       <= raddr_q_r;
          found_cnt_r <= count_now;
        end else if ((chk_r + RW'(1)) == range_r) begin
          val_r <= cand_r;
          exh_r <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      drawn_r   <= $signed(DRAWN_W'(val_r)) + DRAWN_W'(offset_r);
      exh_out_r <= exh_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drawn_value     = drawn_r;
  assign out_table_exhausted = exh_out_r;

  // status to the controller
  always_comb begin
    status.cfg_write  = cfg_we;
    status.apply_pend = apply_pend_r;
    status.cur_pend   = cur_pend_r;
    status.op_draw    = (op_r == OP_DRAW);
    status.div_done   = div_done && !div_busy;
    status.found      = live_r && free;
    status.all_full   = live_r && !free && ((chk_r + RW'(1)) == range_r);
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

[rtl/brd_ctrl.sv]
// Controller: sequences settings recalculation, division, table scan and update.
module brd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brd_pkg::dp_status_t status,
  output brd_pkg::dp_cmd_t    cmd
);
  import brd_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (status.cfg_write) begin
          state_nxt = ST_IDLE;
        end else if (status.apply_pend || status.cur_pend) begin
          state_nxt = ST_RECALC;
        end else if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_RECALC: begin
        if (status.cfg_write || status.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DISPATCH: state_nxt = status.op_draw ? ST_PICK : ST_IDLE;
      ST_PICK: begin
        if (status.div_done) begin
          state_nxt = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (status.found || status.all_full) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_job   = JOB_PICK;
    cmd.scan_init = 1'b0;
    cmd.scan      = 1'b0;
    cmd.update    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!status.cfg_write) begin
          if (status.apply_pend) begin
            cmd.div_start = 1'b1;
            cmd.div_job   = JOB_SNAP;
          end else if (status.cur_pend) begin
            cmd.div_start = 1'b1;
            cmd.div_job   = JOB_CUR;
          end else begin
            in_ready   = 1'b1;
            cmd.accept = in_valid;
          end
        end
      end
      ST_DISPATCH: begin
        if (status.op_draw) begin
          cmd.div_start = 1'b1;
          cmd.div_job   = JOB_PICK;
        end
      end
      ST_SCAN_INIT: cmd.scan_init = 1'b1;
      ST_SCAN:      cmd.scan      = 1'b1;
      ST_UPDATE:    cmd.update    = status.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/balanced_random_draw.sv]
// Top level of the balanced random draw: controller, datapath and channel wiring.
// Draw word: the result is valid soonest when the first candidate is free, and latest
// when the scan walks the whole table (one entry per cycle through the
// use-count memory read port); the 16-step divider sets the base. A draw holds the input
// until its result is registered, longer while the result register is stalled. Clear word:
// dispatch, then idle. Range/total writes cost up to two 16-step divisions; sync reset.
module balanced_random_draw #(
  parameter int MAX_RANGE = brd_pkg::BRD_MAX_RANGE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [brd_pkg::CFG_DW-1:0] cfg_wdata,
  brd_in_if.sink                     in_item,
  brd_out_if.source                  out_item
);
  import brd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready_w;

  brd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready_w),
    .status   (status),
    .cmd      (cmd)
  );

  brd_dp #(
    .MAX_RANGE (MAX_RANGE)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_item.operation),
    .in_random_pick      (in_item.random_pick),
    .in_random_direction (in_item.random_direction),
    .out_ready           (out_item.ready),
    .out_valid           (out_item.valid),
    .out_drawn_value     (out_item.drawn_value),
    .out_table_exhausted (out_item.table_exhausted),
    .cmd                 (cmd),
    .status              (status)
  );

  assign in_item.ready = in_ready_w;

endmodule

[rtl/brd_checker.sv]
// Port-level checks on the balanced random draw, bound to the top level.
module brd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               cfg_we,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [brd_pkg::DRAWN_W-1:0] out_drawn_value,
  input logic                               out_table_exhausted
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drawn_value) &&
                                $stable(out_table_exhausted))
    else $error("result word changed while stalled");

  // one word in flight: ready drops right after an acceptance
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

  // a settings write never coincides with an accepted word
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !(in_valid && in_ready))
    else $error("word accepted during a settings write");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind balanced_random_draw brd_checker u_brd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .cfg_we              (cfg_we),
  .in_valid            (in_item.valid),
  .in_ready            (in_item.ready),
  .out_valid           (out_item.valid),
  .out_ready           (out_item.ready),
  .out_drawn_value     (out_item.drawn_value),
  .out_table_exhausted (out_item.table_exhausted)
);

[test/tb_balanced_random_draw.sv]
// Self-checking testbench for the balanced random draw block: directed table, then random phases.
module tb_balanced_random_draw;
  import brd_pkg::*;

  // Cycles to let pass before a register write: full scan plus two divisions, with margin
  localparam int SETTLE_CYCLES = 160;
  // Long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 28;
  localparam int CLEAR_PCT     = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int DEPTH_LIMIT   = 256;
  localparam int N_DIRECTED    = 20;
  localparam int N_PHASES      = 10;
  // don't-care bits above each register in a write word
  localparam int RANGE_PAD_W   = CFG_DW - RANGE_CFG_W;
  localparam int OFFSET_PAD_W  = CFG_DW - OFFSET_W;

  localparam logic                DIR_UP        = ~DIR_DOWN;
  localparam logic [CFG_IW-1:0]   CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic              op;
    logic [PICK_W-1:0] pick;
    logic              dir;
  } word_t;

  typedef struct packed {
    logic signed [DRAWN_W-1:0] value;
    logic                      exhausted;
  } draw_res_t;

  // One directed word; res is only used where known is set
  typedef struct packed {
    word_t     w;
    bit        known;
    draw_res_t res;
  } stim_row_t;

  // Settings and shape of one random phase
  typedef struct packed {
    logic [CFG_DW-1:0] range_w;
    logic [CFG_DW-1:0] offset_w;
    logic [CFG_DW-1:0] total_w;
    logic [15:0]       words;
    bit                quiet;
    bit                hold;
    bit                pause;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  brd_in_if  in_ch ();
  brd_out_if out_ch ();

  balanced_random_draw u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow state of the draw logic
  logic [CNT_W-1:0]         use_tab [BRD_MAX_RANGE];
  logic [CNT_W-1:0]         depth;
  logic [DRAW_CNT_W-1:0]    draw_cnt;
  bit                       last_round;
  logic [RANGE_CFG_W-1:0]   range_cfg;
  logic signed [OFFSET_W-1:0] offset_cfg;
  logic [TOTAL_W-1:0]       total_cfg;

  draw_res_t expected_draws [$];
  int        fault_count = 0;
  bit        quiet = 1'b0;
  int        hold_asks = 0;

  stim_row_t directed_rows [N_DIRECTED];
  phase_t    phases [N_PHASES];

  function automatic void clear_uses();
    foreach (use_tab[i]) use_tab[i] = '0;
  endfunction

  // Depth follows total / range unless the quotient does not fit
  function automatic void set_total(input logic [TOTAL_W-1:0] t);
    int unsigned q;
    q = t / range_cfg;
    if (q < DEPTH_LIMIT) begin
      depth     = (q < 1) ? CNT_W'(1) : CNT_W'(q);
      total_cfg = t;
    end
  endfunction

  function automatic void reset_shadow();
    range_cfg  = RANGE_CFG_W'(RANGE_RESET);
    offset_cfg = '0;
    total_cfg  = TOTAL_W'(TOTAL_RESET);
    depth      = CNT_W'(1);
    draw_cnt   = '0;
    last_round = 1'b0;
    clear_uses();
  endfunction

  function automatic void shadow_write(input logic [CFG_IW-1:0] idx,
                                       input logic [CFG_DW-1:0] data);
    logic [RANGE_CFG_W-1:0] r;
    case (idx)
      CFG_IDX_RANGE: begin
        r = data[RANGE_CFG_W-1:0];
        if (r < 1) r = RANGE_CFG_W'(1);
        if (r > BRD_MAX_RANGE) r = RANGE_CFG_W'(BRD_MAX_RANGE);
        range_cfg  = r;
        clear_uses();
        last_round = 1'b0;
        set_total(total_cfg);
      end
      CFG_IDX_OFFSET: offset_cfg = data[OFFSET_W-1:0];
      CFG_IDX_TOTAL:  set_total(data[TOTAL_W-1:0]);
      default: ;
    endcase
  endfunction

  // Works out the drawn word for one accepted request; returns 0 for a clear
  function automatic bit predict_draw(input word_t w, output draw_res_t res);
    int unsigned cand, val, pos, i;
    bit found, wrapped, exh;
    found   = 1'b0;
    wrapped = 1'b0;
    exh     = 1'b0;
    res     = '0;
    if (w.op == OP_CLEAR) begin
      clear_uses();
      return 1'b0;
    end
    // count the draw; end of a full cycle restores the depth
    draw_cnt = draw_cnt + 1'b1;
    if (total_cfg != 0 && draw_cnt >= total_cfg) begin
      draw_cnt = '0;
      wrapped  = 1'b1;
    end
    if (wrapped && (total_cfg % range_cfg) != 0) begin
      clear_uses();
      last_round = 1'b0;
      set_total(total_cfg);
    end
    cand = w.pick % range_cfg;
    val  = cand;
    if (use_tab[cand] >= depth) begin
      // walk from the candidate, with wraparound, to the first value not used up
      pos = cand;
      for (i = 0; i < range_cfg && !found; i++) begin
        if (w.dir == DIR_DOWN) pos = (pos == 0) ? range_cfg - 1 : pos - 1;
        else pos = (pos + 1 >= range_cfg) ? 0 : pos + 1;
        if (use_tab[pos] < depth) found = 1'b1;
      end
      if (found) begin
        val = pos;
      end else begin
        // every entry full: last round at depth one when the total does not divide evenly
        if ((total_cfg % range_cfg) != 0 && !last_round) begin
          depth      = CNT_W'(1);
          last_round = 1'b1;
        end
        clear_uses();
        exh = 1'b1;
      end
    end
    use_tab[val] = use_tab[val] + 1'b1;
    res.value     = DRAWN_W'(int'(val) + int'(offset_cfg));
    res.exhausted = exh;
    return 1'b1;
  endfunction

  // Offer one request word, with a random gap first, and predict it on acceptance
  task automatic offer_word(input word_t w, input bit known, input draw_res_t known_res);
    draw_res_t pred;
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= w.op;
    in_ch.random_pick      <= w.pick;
    in_ch.random_direction <= w.dir;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_draw(w, pred)) expected_draws.push_back(known ? known_res : pred);
  endtask

  // Stop offering and wait until every expected word is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_draws.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    shadow_write(idx, data);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random back-pressure, a long hold on request, and the checker
  initial begin
    draw_res_t want;
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_draws.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("unexpected word: value %0d exhausted %0b",
                     out_ch.drawn_value, out_ch.table_exhausted);
        end else begin
          want = expected_draws.pop_front();
          if (out_ch.drawn_value !== want.value ||
              out_ch.table_exhausted !== want.exhausted) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("mismatch: expected value %0d exhausted %0b, got value %0d exhausted %0b",
                       want.value, want.exhausted, out_ch.drawn_value,
                       out_ch.table_exhausted);
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus
  initial begin
    word_t     w;
    phase_t    ph;
    draw_res_t none;
    none = '0;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_IDX_RANGE;
    cfg_wdata              <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= OP_DRAW;
    in_ch.random_pick      <= '0;
    in_ch.random_direction <= DIR_UP;
    reset_shadow();

    // Reset settings: range 12, depth 1. Known values where the table state is obvious.
    directed_rows = '{
      '{'{OP_DRAW,  16'h0000, DIR_UP},   1'b1, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'hFFFF, DIR_DOWN}, 1'b1, '{12'sd3,  1'b0}},
      '{'{OP_DRAW,  16'd12,   DIR_UP},   1'b1, '{12'sd1,  1'b0}},
      '{'{OP_DRAW,  16'd24,   DIR_DOWN}, 1'b1, '{12'sd11, 1'b0}},
      '{'{OP_CLEAR, 16'hFFFF, DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'h0000, DIR_UP},   1'b1, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd1,    DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd2,    DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd3,    DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd4,    DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd5,    DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd6,    DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd7,    DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd8,    DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd9,    DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd10,   DIR_DOWN}, 1'b0, '{12'sd0,  1'b0}},
      '{'{OP_DRAW,  16'd11,   DIR_UP},   1'b0, '{12'sd0,  1'b0}},
      // table now full: cleared, candidate returned
      '{'{OP_DRAW,  16'd5,    DIR_DOWN}, 1'b1, '{12'sd5,  1'b1}},
      '{'{OP_DRAW,  16'd5,    DIR_UP},   1'b1, '{12'sd6,  1'b0}},
      '{'{OP_DRAW,  16'h8000, DIR_DOWN}, 1'b1, '{12'sd8,  1'b0}}
    };

    // Extremes, clamped ranges, ignored totals, uneven totals for the last round
    phases[0] = '{14'd1,   14'h400,  14'd1,     16'd40, 1'b0, 1'b0, 1'b0};
    phases[1] = '{14'd64,  14'h3FF,  14'd16383, 16'd60, 1'b1, 1'b1, 1'b0};
    phases[2] = '{14'd0,   14'd5,    14'd300,   16'd25, 1'b0, 1'b0, 1'b0};
    phases[3] = '{14'd127, 14'h7FF,  14'd0,     16'd60, 1'b0, 1'b0, 1'b0};
    phases[4] = '{14'd7,   14'h7FD,  14'd30,    16'd90, 1'b0, 1'b0, 1'b1};
    phases[5] = '{14'd10,  14'd100,  14'd25,    16'd60, 1'b0, 1'b0, 1'b0};
    phases[6] = '{14'd100, 14'd0,    14'd100,   16'd70, 1'b0, 1'b0, 1'b0};
    phases[7] = '{14'd3,   14'h155,  14'd7,     16'd45, 1'b0, 1'b0, 1'b0};
    for (int p = 8; p < N_PHASES; p++) begin
      phases[p]          = '0;
      phases[p].range_w  = CFG_DW'($urandom_range(1, 20));
      phases[p].offset_w = CFG_DW'($urandom_range(0, 2047));
      phases[p].total_w  = CFG_DW'($urandom_range(1, 200));
      phases[p].words    = 16'd40;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      offer_word(directed_rows[k].w, directed_rows[k].known, directed_rows[k].res);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // a write to the unused index changes nothing
    write_reg(CFG_IDX_SPARE, CFG_DW'($urandom_range(0, 16383)));

    foreach (phases[p]) begin
      ph = phases[p];
      // upper bits beyond each register are don't-care and get random values
      write_reg(CFG_IDX_RANGE,
                {RANGE_PAD_W'($urandom_range(0, 127)), ph.range_w[RANGE_CFG_W-1:0]});
      write_reg(CFG_IDX_OFFSET,
                {OFFSET_PAD_W'($urandom_range(0, 7)), ph.offset_w[OFFSET_W-1:0]});
      write_reg(CFG_IDX_TOTAL, ph.total_w);
      quiet = ph.quiet;
      for (int k = 0; k < ph.words; k++) begin
        if (ph.hold && k == ph.words / 4) hold_asks++;
        if (ph.pause && k == ph.words / 2) wait_drained();
        w.op   = ($urandom_range(0, 99) < CLEAR_PCT) ? OP_CLEAR : OP_DRAW;
        w.pick = PICK_W'($urandom);
        w.dir  = 1'($urandom_range(0, 1));
        offer_word(w, 1'b0, none);
      end
      wait_drained();
      quiet = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (fault_count == 0 && expected_draws.size() == 0) begin
      $display("balanced_random_draw verification clean");
    end else begin
      $display("balanced_random_draw verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("balanced_random_draw verification failed");
    $finish;
  end

endmodule
